// File: rtl/srcnt_pkg.sv
// Package with the transaction types and operation codes of the sorted range counter.
package srcnt_pkg;

  localparam int unsigned CapacityDefault = 1024;
  localparam int unsigned MatchCountW     = 11;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] element_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } srcnt_in_t;

  typedef struct packed {
    logic [MatchCountW-1:0] match_count;
    logic                   overflow_flag;
  } srcnt_out_t;

endpackage

// File: rtl/sorted_range_count_top.sv
// Sorted range counter: sorted store in a synchronous memory, two binary searches per query.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  srcnt_in_t  (operation, value, range)
//   out      output     out_valid_o / out_stall_i srcnt_out_t (match_count, overflow_flag)
//
// One transaction is processed at a time. An append or a clear is accepted in the idle state;
// a clear returns no result, and an append passes to the result state, which moves its result
// into the output register. A query takes one memory read per search step, one step per cycle,
// for each of the two bound searches, then passes to the result state. Reset clears the element
// count and the control state; the memory is not cleared. A stalled output holds the result; a
// new result then waits in the result state, which blocks new input.
module sorted_range_count_top
  import srcnt_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  srcnt_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output srcnt_out_t out_data_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state_q, state_d;

  // Sorted store.
  logic signed [31:0] mem [CAPACITY];
  logic               wr_en;
  logic [AddrW-1:0]   wr_addr;
  logic               rd_en;
  logic [AddrW-1:0]   rd_addr;
  logic signed [31:0] rdata_q;

  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CntW-1:0]    lb_q, lb_d;
  logic signed [31:0] key_q, key_d;
  logic signed [31:0] high_q, high_d;
  logic               upper_q, upper_d;
  srcnt_out_t         res_q, res_d;

  logic               out_valid_q, out_valid_d;
  srcnt_out_t         out_data_q, out_data_d;

  logic               in_fire;
  logic               out_free;
  logic               mid_low;
  logic [CntW-1:0]    lo_n, hi_n, span;
  logic [CntW-1:0]    diff;
  logic [31:0]        diff_ext;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Search step on the element read for mid_q in the previous cycle.
  always_comb begin
    mid_low = upper_q ? (rdata_q <= key_q) : (rdata_q < key_q);
    lo_n    = mid_low ? (mid_q + CntW'(1)) : lo_q;
    hi_n    = mid_low ? hi_q : mid_q;
    span    = hi_n - lo_n;
    diff    = (lo_n > lb_q) ? (lo_n - lb_q) : '0;
  end
  assign diff_ext = 32'(diff);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    lb_d      = lb_q;
    key_d     = key_q;
    high_d    = high_q;
    upper_d   = upper_q;
    res_d     = res_q;
    wr_en     = 1'b0;
    wr_addr   = count_q[AddrW-1:0];
    rd_en     = 1'b0;
    rd_addr   = mid_q[AddrW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data_i.operation)
            OP_APPEND: begin
              res_d.match_count = '0;
              if (count_q < CntW'(CAPACITY)) begin
                wr_en               = 1'b1;
                count_d             = count_q + CntW'(1);
                res_d.overflow_flag = 1'b0;
              end else begin
                res_d.overflow_flag = 1'b1;
              end
              state_d = S_RESULT;
            end
            OP_QUERY: begin
              res_d.match_count   = '0;
              res_d.overflow_flag = 1'b0;
              if ((in_data_i.range_low > in_data_i.range_high) || (count_q == '0)) begin
                state_d = S_RESULT;
              end else begin
                // Lower bound first: first index whose value is >= range_low.
                lo_d    = '0;
                hi_d    = count_q;
                mid_d   = count_q >> 1;
                key_d   = in_data_i.range_low;
                high_d  = in_data_i.range_high;
                upper_d = 1'b0;
                rd_en   = 1'b1;
                rd_addr = mid_d[AddrW-1:0];
                state_d = S_SEARCH;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (lo_n < hi_n) begin
          lo_d    = lo_n;
          hi_d    = hi_n;
          mid_d   = lo_n + (span >> 1);
          rd_en   = 1'b1;
          rd_addr = mid_d[AddrW-1:0];
        end else if (!upper_q) begin
          // Lower bound found; search for the first index whose value is > range_high.
          lb_d    = lo_n;
          lo_d    = '0;
          hi_d    = count_q;
          mid_d   = count_q >> 1;
          key_d   = high_q;
          upper_d = 1'b1;
          rd_en   = 1'b1;
          rd_addr = mid_d[AddrW-1:0];
        end else begin
          res_d.match_count   = diff_ext[MatchCountW-1:0];
          res_d.overflow_flag = 1'b0;
          state_d             = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if ((state_q == S_RESULT) && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data_i.element_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    lb_q       <= lb_d;
    key_q      <= key_d;
    high_q     <= high_d;
    upper_q    <= upper_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: dv/srcnt_checker.sv
// Checker for the sorted range counter: mirrors the store, predicts each result and compares.
module srcnt_checker
  import srcnt_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_o,
  input  srcnt_in_t  in_data_i,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  srcnt_out_t out_data_o,
  output int         mismatch_cnt_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] mirror_vals [CAPACITY];
  int unsigned        mirror_len;
  srcnt_out_t         expected_q [$];

  // First index holding a value >= key, or > key when past_key is set.
  function automatic int unsigned bound_index(logic signed [31:0] key, bit past_key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = mirror_len;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (past_key ? (mirror_vals[mid] <= key) : (mirror_vals[mid] < key)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    srcnt_out_t  want;
    srcnt_out_t  got;
    int unsigned lb;
    int unsigned ub;
    if (!rst_ni) begin
      mirror_len = 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        want = '0;
        case (in_data_i.operation)
          OP_APPEND: begin
            if (mirror_len < CAPACITY) begin
              mirror_vals[mirror_len] = in_data_i.element_value;
              mirror_len++;
            end else begin
              want.overflow_flag = 1'b1;
            end
            expected_q.push_back(want);
          end
          OP_QUERY: begin
            if ($signed(in_data_i.range_low) <= $signed(in_data_i.range_high)
                && mirror_len != 0) begin
              lb = bound_index(in_data_i.range_low, 1'b0);
              ub = bound_index(in_data_i.range_high, 1'b1);
              if (ub > lb) want.match_count = MatchCountW'(ub - lb);
            end
            expected_q.push_back(want);
          end
          OP_CLEAR: mirror_len = 0;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction, match_count %0d overflow_flag %0b",
                   $time, got.match_count, got.overflow_flag);
          mismatch_cnt_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.match_count !== want.match_count) begin
            $display("%0t: match_count expected %0d, actual %0d",
                     $time, want.match_count, got.match_count);
            mismatch_cnt_o++;
          end
          if (got.overflow_flag !== want.overflow_flag) begin
            $display("%0t: overflow_flag expected %0b, actual %0b",
                     $time, want.overflow_flag, got.overflow_flag);
            mismatch_cnt_o++;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// File: dv/sorted_range_count_top_test.sv
// Testbench top for the sorted range counter: drives appends, queries and clears.
module sorted_range_count_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import srcnt_pkg::*;

  localparam int unsigned        Capacity  = CapacityDefault;
  localparam logic signed [31:0] MinVal    = 32'sh8000_0000;
  localparam logic signed [31:0] MaxVal    = 32'sh7fff_ffff;
  localparam logic [1:0]         OpIgnored = 2'd3;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  srcnt_in_t  in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  srcnt_out_t out_data_o;

  int mismatch_cnt;
  int pending_cnt;
  int idle_pct;
  int stall_pct;
  int phase_items;
  int idle_tbl   [4] = '{0, 69, 0, 29};
  int stall_tbl  [4] = '{0, 0, 69, 29};
  int budget_tbl [4] = '{100, 260, 260, 260};

  // Values the store should hold, used to aim query limits and to pick the next sorted value.
  logic signed [31:0] held_vals [$];

  sorted_range_count_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  srcnt_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin : watchdog
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transaction is taken.
  task automatic issue(input logic [1:0] op, input logic signed [31:0] value,
                       input logic signed [31:0] low, input logic signed [31:0] high);
    srcnt_in_t item;
    item.operation     = op;
    item.element_value = value;
    item.range_low     = low;
    item.range_high    = high;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    case (op)
      OP_APPEND: if (held_vals.size() < Capacity) held_vals.push_back(value);
      OP_CLEAR:  held_vals.delete();
      default: ;
    endcase
    if (op != OpIgnored) phase_items++;
  endtask

  // Next value that keeps the store non-decreasing, with duplicates and wide steps.
  function automatic logic signed [31:0] next_sorted();
    longint v;
    if (held_vals.size() == 0) begin
      case ($urandom_range(3))
        0:       v = MinVal;
        1:       v = int'($urandom);
        default: v = longint'($urandom_range(2000)) - 1000;
      endcase
    end else begin
      v = held_vals[$];
      case ($urandom_range(9))
        0, 1:       ;
        2, 3, 4, 5: v += $urandom_range(1, 3);
        6, 7, 8:    v += $urandom_range(1, 1 << 20);
        default:    v += $urandom_range(1, 1 << 28);
      endcase
    end
    if (v > MaxVal) v = MaxVal;
    return v[31:0];
  endfunction

  // Query limit near a held value, at an extreme, or anywhere.
  function automatic logic signed [31:0] pick_key();
    longint base;
    longint k;
    if (held_vals.size() != 0) base = held_vals[$urandom_range(held_vals.size() - 1)];
    else base = int'($urandom);
    case ($urandom_range(5))
      0:       k = base;
      1:       k = base - 1;
      2:       k = base + 1;
      3:       k = int'($urandom);
      4:       k = MinVal;
      default: k = MaxVal;
    endcase
    if (k > MaxVal) k = MaxVal;
    if (k < MinVal) k = MinVal;
    return k[31:0];
  endfunction

  task automatic random_query();
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] t;
    a = pick_key();
    b = pick_key();
    // Most ranges are ordered; the rest may have low above high.
    if ($urandom_range(9) < 8 && a > b) begin
      t = a;
      a = b;
      b = t;
    end
    issue(OP_QUERY, $urandom, a, b);
  endtask

  task automatic random_traffic(input int budget);
    int r;
    int n;
    while (phase_items < budget) begin
      r = $urandom_range(99);
      if (r < 6) begin
        issue(OP_CLEAR, $urandom, $urandom, $urandom);
      end else if (r < 40) begin
        n = (r < 9) ? $urandom_range(60, 200) : $urandom_range(1, 16);
        repeat (n) issue(OP_APPEND, next_sorted(), $urandom, $urandom);
      end else if (r < 92) begin
        random_query();
      end else if (r < 96) begin
        issue(OpIgnored, $urandom, $urandom, $urandom);
      end else begin
        // An append that may break the sort order.
        issue(OP_APPEND, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Called at a falling edge; the sender stays quiet until every result has come.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    phase_items = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    issue(OP_QUERY, $urandom, MinVal, MaxVal);
    issue(OpIgnored, $urandom, $urandom, $urandom);
    issue(OP_CLEAR, $urandom, $urandom, $urandom);
    issue(OP_APPEND, -100, $urandom, $urandom);
    issue(OP_APPEND, 5, $urandom, $urandom);
    issue(OP_APPEND, 5, $urandom, $urandom);
    issue(OP_APPEND, 200, $urandom, $urandom);
    // High limit below the first element must count nothing.
    issue(OP_QUERY, $urandom, MinVal, -101);
    issue(OP_QUERY, $urandom, 5, 5);
    issue(OP_QUERY, $urandom, 201, MaxVal);
    issue(OP_QUERY, $urandom, 200, -100);
    issue(OP_QUERY, $urandom, -100, 200);
    issue(OP_CLEAR, $urandom, $urandom, $urandom);
    issue(OP_APPEND, MinVal, $urandom, $urandom);
    issue(OP_APPEND, MaxVal, $urandom, $urandom);
    issue(OP_QUERY, $urandom, MinVal, MaxVal);
    issue(OP_QUERY, $urandom, MaxVal, MaxVal);
    issue(OP_QUERY, $urandom, MinVal, MinVal);
    issue(OP_QUERY, $urandom, MaxVal, MinVal);
    issue(OP_CLEAR, $urandom, $urandom, $urandom);
    issue(OP_QUERY, $urandom, -5, 5);

    // Fill the store completely, then push two appends past the end.
    issue(OP_CLEAR, $urandom, $urandom, $urandom);
    repeat (Capacity + 2) issue(OP_APPEND, next_sorted(), $urandom, $urandom);
    repeat (8) random_query();
    issue(OP_QUERY, $urandom, MinVal, MaxVal);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      idle_pct    = idle_tbl[p];
      stall_pct   = stall_tbl[p];
      phase_items = 0;
      random_traffic(budget_tbl[p]);
    end
    wait_idle();

    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sorted_range_count_top.f
rtl/srcnt_pkg.sv
rtl/sorted_range_count_top.sv
dv/srcnt_checker.sv
dv/sorted_range_count_top_test.sv
